>>> hdl/tc_pkg.sv
// ----------------------------------------------------------------------------
// tc_pkg: shared types and constants for the tetrahedron circumcentre block
// Result record, status codes and width helpers for the datapath.
// ----------------------------------------------------------------------------
package tc_pkg;

  localparam int OUT_W = 48;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
    status_e          status;
  } res_t;

  // Dividend/quotient width: |num| << (F+1) plus divisor
  function automatic int tc_quo_w(int c, int f);
    return 4 * (c + 1) + 6 + f + 2;
  endfunction

  // Divisor width: 2 * |2 * det|
  function automatic int tc_dvs_w(int c);
    return 3 * (c + 1) + 5;
  endfunction

endpackage

>>> hdl/tetrahedron_circumcenter.sv
// ----------------------------------------------------------------------------
// tetrahedron_circumcenter: centre of the sphere through four 3D points
// Cramer's rule on the bisector system, rounded fixed-point division.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid_i / in_stall_o carry one request, four points
//   p1..p4 of signed COORD_BITS coordinates. A request is taken on a rising
//   edge with in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o / out_stall_i carry one result per request:
//   centre x/y/z in signed 48-bit fixed point (FRAC_BITS fraction bits),
//   rounded to nearest with ties away from zero, and a status code.
//   Path: the front-end registers, then the divider with one quotient bit
//   per stage (QW bits, 92 with default parameters), then the output
//   register. The quotient-bit pipeline makes up most of the path.
//   Throughput: one request per cycle while the pipe is not stalled; the
//   divider holds one request per stage and all lanes share the stage timing.
//   Reset clears every valid bit; the pipe comes out empty and ready.
//   When the receiver stalls, the next valid result parks in a skid register;
//   in_stall_o follows the skid valid bit, freezing the pipe; nothing is dropped.
// ----------------------------------------------------------------------------
module tetrahedron_circumcenter #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] p1_x_i,
  input  logic signed [COORD_BITS-1:0] p1_y_i,
  input  logic signed [COORD_BITS-1:0] p1_z_i,
  input  logic signed [COORD_BITS-1:0] p2_x_i,
  input  logic signed [COORD_BITS-1:0] p2_y_i,
  input  logic signed [COORD_BITS-1:0] p2_z_i,
  input  logic signed [COORD_BITS-1:0] p3_x_i,
  input  logic signed [COORD_BITS-1:0] p3_y_i,
  input  logic signed [COORD_BITS-1:0] p3_z_i,
  input  logic signed [COORD_BITS-1:0] p4_x_i,
  input  logic signed [COORD_BITS-1:0] p4_y_i,
  input  logic signed [COORD_BITS-1:0] p4_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [tc_pkg::OUT_W-1:0] center_x_o,
  output logic signed [tc_pkg::OUT_W-1:0] center_y_o,
  output logic signed [tc_pkg::OUT_W-1:0] center_z_o,
  output logic [1:0]                   status_o
);
  import tc_pkg::*;

  localparam int QW = tc_quo_w(COORD_BITS, FRAC_BITS);
  localparam int VW = tc_dvs_w(COORD_BITS);
  // quotient widened so the 2^47 bounds always fit
  localparam int EW = (QW > OUT_W + 1) ? QW : OUT_W + 1;

  logic signed [COORD_BITS-1:0] pt [4][3];

  logic          en;
  logic          fe_v, fe_dg, dv_v, dv_dg;
  logic [2:0]    fe_ng, dv_ng;
  logic [QW-1:0] fe_dvd [3];
  logic [QW-1:0] quo    [3];
  logic [VW-1:0] fe_dvs;

  res_t res_new, out_q, skid_q;
  logic out_v_q, skid_v_q;

  assign pt[0] = '{p1_x_i, p1_y_i, p1_z_i};
  assign pt[1] = '{p2_x_i, p2_y_i, p2_z_i};
  assign pt[2] = '{p3_x_i, p3_y_i, p3_z_i};
  assign pt[3] = '{p4_x_i, p4_y_i, p4_z_i};

  // whole pipe moves unless the skid register is holding a result
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  tc_front #(
    .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .QW(QW), .VW(VW)
  ) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .pt_i(pt),
    .valid_o(fe_v), .degen_o(fe_dg), .neg_o(fe_ng), .dvd_o(fe_dvd), .dvs_o(fe_dvs)
  );

  tc_div #(.QW(QW), .VW(VW)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fe_v), .degen_i(fe_dg), .neg_i(fe_ng),
    .dvd_i(fe_dvd), .dvs_i(fe_dvs),
    .valid_o(dv_v), .degen_o(dv_dg), .neg_o(dv_ng), .quo_o(quo)
  );

  // sign, saturation and degenerate override
  always_comb begin
    logic [EW-1:0]    qe;
    logic [OUT_W-1:0] val [3];
    logic             sat;
    sat = 1'b0;
    for (int j = 0; j < 3; j++) begin
      qe = EW'(quo[j]);
      if (!dv_ng[j] && qe > EW'(64'h0000_7FFF_FFFF_FFFF)) begin
        val[j] = OUT_W'(64'h0000_7FFF_FFFF_FFFF);
        sat    = 1'b1;
      end else if (dv_ng[j] && qe > EW'(64'h0000_8000_0000_0000)) begin
        val[j] = OUT_W'(64'h0000_8000_0000_0000);
        sat    = 1'b1;
      end else begin
        val[j] = dv_ng[j] ? OUT_W'(-qe) : OUT_W'(qe);
      end
    end
    if (dv_dg) begin
      res_new = '{x: '0, y: '0, z: '0, status: ST_DEGEN};
    end else begin
      res_new = '{x: val[0], y: val[1], z: val[2], status: sat ? ST_SAT : ST_OK};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (!(out_v_q && out_stall_i)) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (out_v_q && out_stall_i) begin
      skid_v_q <= dv_v;
    end else begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (!(out_v_q && out_stall_i)) out_q <= skid_q;
    end else if (out_v_q && out_stall_i) begin
      skid_q <= res_new;
    end else begin
      out_q <= res_new;
    end
  end

  assign out_valid_o = out_v_q;
  assign center_x_o  = out_q.x;
  assign center_y_o  = out_q.y;
  assign center_z_o  = out_q.z;
  assign status_o    = out_q.status;

endmodule

>>> hdl/tc_front.sv
// ----------------------------------------------------------------------------
// tc_front: determinant front end
// Differences, minors, products, Cramer sums and divider operand set-up.
// ----------------------------------------------------------------------------
module tc_front #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16,
  parameter int QW         = 92,
  parameter int VW         = 56
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] pt_i [4][3],
  output logic                         valid_o,
  output logic                         degen_o,
  output logic [2:0]                   neg_o,
  output logic [QW-1:0]                dvd_o [3],
  output logic [VW-1:0]                dvs_o
);
  import tc_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int DW  = C + 1;
  localparam int MW  = 2 * DW + 1;
  localparam int RW  = 2 * DW + 2;
  localparam int TW  = 3 * DW + 1;
  localparam int UW  = 4 * DW + 3;
  localparam int DTW = 3 * DW + 3;
  localparam int DSW = 4 * DW + 5;
  localparam int NW  = 4 * DW + 6;

  logic                 v_q [6];
  logic signed [DW-1:0] d1_q [3][3];
  logic signed [C-1:0]  p1_q [4][3];
  logic signed [RW-1:0] r2_q [3];
  logic signed [MW-1:0] m2_q [3][3];
  logic signed [DW-1:0] d2_q [3];
  logic signed [TW-1:0] t3_q [3];
  logic signed [UW-1:0] u3_q [3][3];
  logic signed [DTW-1:0] det4_q;
  logic signed [DSW-1:0] dets4_q [3];
  logic signed [NW-1:0]  num5_q [3];
  logic signed [DTW:0]   tdet5_q;
  logic                  zero5_q;

  logic signed [DW-1:0]  d1_d [3][3];
  logic signed [RW-1:0]  r2_d [3];
  logic signed [MW-1:0]  m2_d [3][3];
  logic signed [DTW-1:0] det4_d;
  logic signed [DSW-1:0] dets4_d [3];
  logic signed [DTW:0]   tdet5_d;
  logic signed [NW-1:0]  num5_d [3];
  logic [NW-1:0]         mag6 [3];
  logic [DTW:0]          b6;

  always_comb begin
    int ra, rb, ca, cb;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        d1_d[i][j] = DW'(pt_i[i+1][j]) - DW'(pt_i[0][j]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      r2_d[i] = RW'(d1_q[i][0]) * RW'(d1_q[i][0]) + RW'(d1_q[i][1]) * RW'(d1_q[i][1])
              + RW'(d1_q[i][2]) * RW'(d1_q[i][2]);
      ra = (i == 0) ? 1 : 0;
      rb = (i == 2) ? 1 : 2;
      for (int j = 0; j < 3; j++) begin
        ca = (j == 0) ? 1 : 0;
        cb = (j == 2) ? 1 : 2;
        m2_d[i][j] = MW'(d1_q[ra][ca]) * MW'(d1_q[rb][cb])
                   - MW'(d1_q[ra][cb]) * MW'(d1_q[rb][ca]);
      end
    end
    det4_d = DTW'(t3_q[0]) - DTW'(t3_q[1]) + DTW'(t3_q[2]);
    for (int j = 0; j < 3; j++) begin
      dets4_d[j] = '0;
      for (int i = 0; i < 3; i++) begin
        if (((i + j) & 1) != 0) dets4_d[j] = dets4_d[j] - DSW'(u3_q[i][j]);
        else                    dets4_d[j] = dets4_d[j] + DSW'(u3_q[i][j]);
      end
    end
    tdet5_d = $signed({det4_q, 1'b0});
    for (int j = 0; j < 3; j++) begin
      num5_d[j] = NW'(p1_q[3][j]) * NW'(tdet5_d) + NW'(dets4_q[j]);
      mag6[j]   = num5_q[j][NW-1] ? NW'(-num5_q[j]) : NW'(num5_q[j]);
    end
    b6 = tdet5_q[DTW] ? (DTW+1)'(-tdet5_q) : (DTW+1)'(tdet5_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < 6; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q <= d1_d;
      for (int j = 0; j < 3; j++) begin
        p1_q[0][j] <= pt_i[0][j];
        for (int k = 1; k < 4; k++) p1_q[k][j] <= p1_q[k-1][j];
        d2_q[j] <= d1_q[0][j];
        t3_q[j] <= TW'(d2_q[j]) * TW'(m2_q[0][j]);
        for (int i = 0; i < 3; i++) u3_q[i][j] <= UW'(r2_q[i]) * UW'(m2_q[i][j]);
        neg_o[j] <= num5_q[j][NW-1] ^ tdet5_q[DTW];
        dvd_o[j] <= (QW'(mag6[j]) << (FRAC_BITS + 1)) + QW'(b6);
      end
      r2_q    <= r2_d;
      m2_q    <= m2_d;
      det4_q  <= det4_d;
      dets4_q <= dets4_d;
      num5_q  <= num5_d;
      tdet5_q <= tdet5_d;
      zero5_q <= (det4_q == '0);
      degen_o <= zero5_q;
      dvs_o   <= VW'({b6, 1'b0});
    end
  end

  assign valid_o = v_q[5];

endmodule

>>> hdl/tc_div.sv
// ----------------------------------------------------------------------------
// tc_div: pipelined restoring divider, three lanes, shared divisor
// One quotient bit per stage; dividend and quotient share one shift register.
// ----------------------------------------------------------------------------
module tc_div #(
  parameter int QW = 92,
  parameter int VW = 56
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic          degen_i,
  input  logic [2:0]    neg_i,
  input  logic [QW-1:0] dvd_i [3],
  input  logic [VW-1:0] dvs_i,
  output logic          valid_o,
  output logic          degen_o,
  output logic [2:0]    neg_o,
  output logic [QW-1:0] quo_o [3]
);
  import tc_pkg::*;

  logic          v_q   [QW];
  logic          dg_q  [QW];
  logic [2:0]    ng_q  [QW];
  logic [VW-1:0] dv_q  [QW];
  logic [VW-1:0] rem_q [QW][3];
  logic [QW-1:0] nq_q  [QW][3];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_in, dg_in;
    logic [2:0]    ng_in;
    logic [VW-1:0] dv_in;
    logic [VW-1:0] rem_in [3];
    logic [QW-1:0] nq_in  [3];
    logic [VW-1:0] rem_d  [3];
    logic [QW-1:0] nq_d   [3];

    if (k == 0) begin : g_first
      assign v_in  = valid_i;
      assign dg_in = degen_i;
      assign ng_in = neg_i;
      assign dv_in = dvs_i;
      for (genvar l = 0; l < 3; l++) begin : g_l
        assign rem_in[l] = '0;
        assign nq_in[l]  = dvd_i[l];
      end
    end else begin : g_next
      assign v_in  = v_q[k-1];
      assign dg_in = dg_q[k-1];
      assign ng_in = ng_q[k-1];
      assign dv_in = dv_q[k-1];
      for (genvar l = 0; l < 3; l++) begin : g_l
        assign rem_in[l] = rem_q[k-1][l];
        assign nq_in[l]  = nq_q[k-1][l];
      end
    end

    always_comb begin
      logic [VW:0] sh;
      logic        ge;
      for (int l = 0; l < 3; l++) begin
        sh = {rem_in[l], nq_in[l][QW-1]};
        ge = (sh >= {1'b0, dv_in});
        rem_d[l] = ge ? VW'(sh - {1'b0, dv_in}) : VW'(sh);
        nq_d[l]  = {nq_in[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dg_q[k]  <= dg_in;
        ng_q[k]  <= ng_in;
        dv_q[k]  <= dv_in;
        rem_q[k] <= rem_d;
        nq_q[k]  <= nq_d;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign degen_o = dg_q[QW-1];
  assign neg_o   = ng_q[QW-1];
  assign quo_o   = nq_q[QW-1];

endmodule

>>> hdl/tc_checker.sv
// ----------------------------------------------------------------------------
// tc_checker: port-level checks for the circumcentre block
// Valid and status hold under stall, status codes, degenerate zeros and back-pressure timing.
// ----------------------------------------------------------------------------
module tc_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [tc_pkg::OUT_W-1:0] center_x_o,
  input logic [tc_pkg::OUT_W-1:0] center_y_o,
  input logic [tc_pkg::OUT_W-1:0] center_z_o,
  input logic [1:0]               status_o
);
  import tc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("unknown status code");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DEGEN |->
      center_x_o == '0 && center_y_o == '0 && center_z_o == '0)
    else $error("degenerate result not zero");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

endmodule

bind tetrahedron_circumcenter tc_checker u_tc_checker (.*);
